### rtl/motor_reversal_relay_sequencer_core_macros.svh
// Assertion macros shared by the relay sequencer RTL.
`ifndef MOTOR_REVERSAL_RELAY_SEQUENCER_CORE_MACROS_SVH
`define MOTOR_REVERSAL_RELAY_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RMS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rms_pkg.sv
// Types, codes and constants of the motor reversal relay sequencer.
package rms_pkg;

  localparam int unsigned CountWidth   = 16;
  localparam int unsigned RelayCount   = 10;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned CfgIdxWidth  = 1;
  localparam int unsigned InDataWidth  = 16;
  localparam int unsigned InUserWidth  = 2;
  localparam int unsigned OutDataWidth = 16;

  localparam logic [CfgDataWidth-1:0] RevTicksReset   = 16'd50;
  localparam logic [CfgDataWidth-1:0] PulseTicksReset = 16'd10;

  // Relay bit positions (bit i is relay i+1).
  localparam int unsigned RlyAux     = 0;
  localparam int unsigned RlyBooster = 1;
  localparam int unsigned RlyLeft    = 2;
  localparam int unsigned RlyRight   = 3;
  localparam int unsigned RlyPerc    = 4;
  localparam int unsigned RlyPumpA   = 5;
  localparam int unsigned RlyPumpB   = 6;
  localparam int unsigned RlyFert    = 7;
  localparam int unsigned RlyStart   = 8;
  localparam int unsigned RlyIdle    = 9;

  typedef enum logic [1:0] {
    CmdRefresh = 2'd0,
    CmdTick    = 2'd1,
    CmdAllOff  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    DirOff   = 2'd0,
    DirRight = 2'd1,
    DirLeft  = 2'd2
  } dir_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgRevTicks   = 1'b0,
    CfgPulseTicks = 1'b1
  } cfg_idx_e;

  typedef logic [CountWidth-1:0] cnt_t;
  typedef logic [RelayCount-1:0] relay_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] motor_dir;
    logic       aux_contact;
    logic       irrigation_mode;
    logic       wait_pressure;
    logic       wait_start;
    logic       main_pump;
    logic       fertigation;
    logic       booster_override;
    logic       booster;
    logic       percentimeter;
  } item_t;

  typedef struct packed {
    dir_e   last_dir;
    cnt_t   rev_cnt;
    cnt_t   pulse_cnt;
    relay_t relays;
  } state_t;

endpackage

### rtl/rms_step.sv
// Next-state and result logic for one command of the relay sequencer.
module rms_step (
  input  rms_pkg::item_t  item_i,
  input  rms_pkg::state_t state_i,
  input  rms_pkg::cnt_t   rev_load_i,
  input  rms_pkg::cnt_t   pulse_load_i,
  output rms_pkg::state_t state_o,
  output logic            reversing_o
);

  // Counter is armed when sitting at its load value.
  function automatic rms_pkg::cnt_t start_count(rms_pkg::cnt_t cnt, rms_pkg::cnt_t load);
    rms_pkg::cnt_t res;
    res = cnt;
    if (cnt == load) begin
      res = (load == '0) ? '0 : load - rms_pkg::cnt_t'(1);
    end
    return res;
  endfunction

  function automatic rms_pkg::cnt_t tick_count(rms_pkg::cnt_t cnt, rms_pkg::cnt_t load);
    rms_pkg::cnt_t res;
    res = cnt;
    if ((cnt != load) && (cnt != '0)) begin
      res = cnt - rms_pkg::cnt_t'(1);
    end
    return res;
  endfunction

  rms_pkg::dir_e dir;
  rms_pkg::dir_e opposite;
  logic          right;

  // Direction code three behaves as left.
  always_comb begin
    if (item_i.motor_dir == rms_pkg::DirOff) begin
      dir = rms_pkg::DirOff;
    end else if (item_i.motor_dir == rms_pkg::DirRight) begin
      dir = rms_pkg::DirRight;
    end else begin
      dir = rms_pkg::DirLeft;
    end
    right    = (dir == rms_pkg::DirRight);
    opposite = right ? rms_pkg::DirLeft : rms_pkg::DirRight;
  end

  always_comb begin
    rms_pkg::state_t st;
    rms_pkg::cnt_t   rc;
    st = state_i;
    rc = '0;
    unique case (rms_pkg::cmd_e'(item_i.cmd))
      rms_pkg::CmdRefresh: begin
        st.relays[rms_pkg::RlyAux] = item_i.aux_contact;
        if (dir == rms_pkg::DirOff) begin
          st.relays[rms_pkg::RlyStart] = 1'b0;
          st.relays[rms_pkg::RlyIdle]  = 1'b1;
          st.relays[rms_pkg::RlyLeft]  = 1'b0;
          st.relays[rms_pkg::RlyRight] = 1'b0;
          st.rev_cnt   = rev_load_i;
          st.pulse_cnt = pulse_load_i;
          st.last_dir  = rms_pkg::DirOff;
        end else if (state_i.last_dir == opposite) begin
          // Reversal: open both contactors, close new side after dead time.
          st.relays[rms_pkg::RlyIdle]  = 1'b0;
          st.relays[rms_pkg::RlyLeft]  = 1'b0;
          st.relays[rms_pkg::RlyRight] = 1'b0;
          rc = start_count(state_i.rev_cnt, rev_load_i);
          st.rev_cnt = rc;
          if (rc == '0) begin
            st.relays[rms_pkg::RlyRight] = right;
            st.relays[rms_pkg::RlyLeft]  = !right;
            st.last_dir = dir;
          end
        end else begin
          st.pulse_cnt = start_count(state_i.pulse_cnt, pulse_load_i);
          st.relays[rms_pkg::RlyStart] = (st.pulse_cnt != '0);
          st.relays[rms_pkg::RlyIdle]  = 1'b0;
          st.relays[rms_pkg::RlyRight] = right;
          st.relays[rms_pkg::RlyLeft]  = !right;
          st.rev_cnt  = rev_load_i;
          st.last_dir = dir;
        end
        if (item_i.irrigation_mode) begin
          st.relays[rms_pkg::RlyPumpA] = item_i.main_pump;
          st.relays[rms_pkg::RlyPumpB] = item_i.main_pump;
          if (item_i.wait_pressure || item_i.wait_start) begin
            st.relays[rms_pkg::RlyFert]    = 1'b0;
            st.relays[rms_pkg::RlyBooster] = 1'b0;
            st.relays[rms_pkg::RlyPerc]    = 1'b0;
          end else begin
            st.relays[rms_pkg::RlyFert]    = item_i.fertigation;
            st.relays[rms_pkg::RlyBooster] = item_i.booster_override | item_i.booster;
            st.relays[rms_pkg::RlyPerc]    = item_i.percentimeter;
          end
        end else begin
          st.relays[rms_pkg::RlyFert]    = 1'b0;
          st.relays[rms_pkg::RlyBooster] = 1'b0;
          st.relays[rms_pkg::RlyPerc]    = item_i.percentimeter;
          st.relays[rms_pkg::RlyPumpA]   = 1'b0;
          st.relays[rms_pkg::RlyPumpB]   = 1'b0;
        end
      end
      rms_pkg::CmdTick: begin
        st.rev_cnt   = tick_count(state_i.rev_cnt, rev_load_i);
        st.pulse_cnt = tick_count(state_i.pulse_cnt, pulse_load_i);
      end
      rms_pkg::CmdAllOff: begin
        st.relays = '0;
      end
      default: begin
        // unused command code: state kept
      end
    endcase
    state_o     = st;
    reversing_o = (st.rev_cnt != rev_load_i) && (st.rev_cnt != '0);
  end

endmodule

### rtl/motor_reversal_relay_sequencer_core.sv
// Top level of the motor reversal relay sequencer.
// Drives ten relays from control flags carried by each input transaction.
// The command (tuser) selects a refresh of all relays from the flags, a time
// tick that counts down the reversal dead time and start pulse counters, or
// switching every relay off. A change between right and left first opens both
// direction contactors and only closes the new side once the dead time has
// counted down on ticks; the start relay is held for pulse_ticks minus one
// ticks after the motor leaves off. Every transaction returns exactly one result:
// the relay states after the command and a flag that is high while a reversal
// dead time runs. Throughput is one transaction per clock; the path from input
// to output runs through the input register and the result register with the
// single step of combinational update logic between them. Both sides may
// stall freely; the input is still taken while a result waits, as long as the
// held item can move into the result register in the same cycle.
// Configuration writes (index 0 reversal_ticks, index 1 pulse_ticks) take
// effect at once and are meant to be done while no transaction is in flight.
`include "motor_reversal_relay_sequencer_core_macros.svh"

module motor_reversal_relay_sequencer_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] motor_dir, [2] aux_contact, [3] irrigation_mode, [4] wait_pressure,
  // [5] wait_start, [6] main_pump, [7] fertigation, [8] booster_override,
  // [9] booster, [10] percentimeter, [15:11] zero
  input  logic [rms_pkg::InDataWidth-1:0]    s_axis_tdata,
  // [1:0] cmd
  input  logic [rms_pkg::InUserWidth-1:0]    s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [9:0] relay_mask, [10] reversing, [15:11] zero
  output logic [rms_pkg::OutDataWidth-1:0]   m_axis_tdata,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [rms_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [rms_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  // configuration registers
  logic [rms_pkg::CfgDataWidth-1:0] rev_ticks_q;
  logic [rms_pkg::CfgDataWidth-1:0] pulse_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_ticks_q   <= rms_pkg::RevTicksReset;
      pulse_ticks_q <= rms_pkg::PulseTicksReset;
    end else if (cfg_we_i) begin
      unique case (rms_pkg::cfg_idx_e'(cfg_idx_i))
        rms_pkg::CfgRevTicks:   rev_ticks_q   <= cfg_data_i;
        rms_pkg::CfgPulseTicks: pulse_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // counter load values, cut or widened to the counter width
  rms_pkg::cnt_t rev_load;
  rms_pkg::cnt_t pulse_load;
  assign rev_load   = rms_pkg::cnt_t'(rev_ticks_q);
  assign pulse_load = rms_pkg::cnt_t'(pulse_ticks_q);

  // input register
  logic           in_valid_q;
  rms_pkg::item_t in_item_q;
  rms_pkg::item_t in_item_d;
  logic           out_valid_q;
  logic           adv;     // held item moves into the result register
  logic           in_take; // input transaction

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_item_d.cmd              = s_axis_tuser;
    in_item_d.motor_dir        = s_axis_tdata[1:0];
    in_item_d.aux_contact      = s_axis_tdata[2];
    in_item_d.irrigation_mode  = s_axis_tdata[3];
    in_item_d.wait_pressure    = s_axis_tdata[4];
    in_item_d.wait_start       = s_axis_tdata[5];
    in_item_d.main_pump        = s_axis_tdata[6];
    in_item_d.fertigation      = s_axis_tdata[7];
    in_item_d.booster_override = s_axis_tdata[8];
    in_item_d.booster          = s_axis_tdata[9];
    in_item_d.percentimeter    = s_axis_tdata[10];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_d;
    end
  end

  // sequencer state, updated as the item moves to the result register
  rms_pkg::state_t st_q;
  rms_pkg::state_t st_d;
  logic            reversing_d;

  rms_step u_step (
    .item_i       (in_item_q),
    .state_i      (st_q),
    .rev_load_i   (rev_load),
    .pulse_load_i (pulse_load),
    .state_o      (st_d),
    .reversing_o  (reversing_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.last_dir  <= rms_pkg::DirOff;
      st_q.rev_cnt   <= rms_pkg::cnt_t'(rms_pkg::RevTicksReset);
      st_q.pulse_cnt <= rms_pkg::cnt_t'(rms_pkg::PulseTicksReset);
      st_q.relays    <= '0;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  // result register
  rms_pkg::relay_t out_relays_q;
  logic            out_rev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_relays_q <= st_d.relays;
      out_rev_q    <= reversing_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {
    (rms_pkg::OutDataWidth - rms_pkg::RelayCount - 1)'(0), out_rev_q, out_relays_q
  };

  // both direction contactors are never closed together
  `RMS_ASSERT_IMPL(a_dir_exclusive, 1'b1,
      !(st_q.relays[rms_pkg::RlyLeft] && st_q.relays[rms_pkg::RlyRight]),
      "both direction contactors closed")
  // a new result only comes from a held input item
  `RMS_ASSERT_IMPL(a_result_source, $rose(out_valid_q), $past(in_valid_q),
      "result without input item")
  // state only moves when an item is processed
  `RMS_ASSERT_NEXT(a_state_hold, !adv, $stable(st_q),
      "state changed without a processed item")

endmodule

### test/motor_reversal_relay_sequencer_core_tb.sv
// Testbench of the motor reversal relay sequencer: directed table, then random phases.
`timescale 1ns / 1ps

module motor_reversal_relay_sequencer_core_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PlanRows = 20;
  // Codes outside the named enums: reserved command, alternate left encoding.
  localparam logic [1:0] CmdReserved = 2'd3;
  localparam logic [1:0] DirLeftAlt = 2'd3;

  typedef struct packed {
    rms_pkg::relay_t mask;
    logic            reversing;
  } relay_result_t;

  // flags, MSB first: aux irr wait_p wait_s pump fert ovr boost perc
  typedef struct packed {
    logic [1:0]      cmd;
    logic [1:0]      dir;
    logic [8:0]      flags;
    bit              typed;
    rms_pkg::relay_t mask;
    logic            reversing;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [rms_pkg::InDataWidth-1:0] s_axis_tdata = '0;
  logic [rms_pkg::InUserWidth-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [rms_pkg::OutDataWidth-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [rms_pkg::CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [rms_pkg::CfgDataWidth-1:0] cfg_data_i = '0;

  // Shadow of the block: timing registers and sequencer state.
  rms_pkg::cnt_t   rev_ticks = rms_pkg::RevTicksReset;
  rms_pkg::cnt_t   pulse_ticks = rms_pkg::PulseTicksReset;
  rms_pkg::dir_e   last_dir = rms_pkg::DirOff;
  rms_pkg::cnt_t   rev_cnt = rms_pkg::RevTicksReset;
  rms_pkg::cnt_t   pulse_cnt = rms_pkg::PulseTicksReset;
  rms_pkg::relay_t relays = '0;

  relay_result_t expected_relays [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit calm = 1'b0;                     // phase with no idling on either side
  logic [1:0] steer = rms_pkg::DirOff; // direction the random operator is asking for
  int sink_hold = 0;

  // Directed table, under the reset timing (dead time 50, pulse 10).
  plan_row_t plan [PlanRows] = '{
    '{rms_pkg::CmdRefresh, rms_pkg::DirOff,   9'h000,       1'b1, 10'h200, 1'b0},
    '{rms_pkg::CmdRefresh, rms_pkg::DirOff,   9'h1FF,       1'b1, 10'h261, 1'b0},
    '{rms_pkg::CmdRefresh, rms_pkg::DirOff,   9'b010011101, 1'b1, 10'h2F2, 1'b0},
    '{rms_pkg::CmdAllOff,  rms_pkg::DirOff,   9'h1FF,       1'b1, 10'h000, 1'b0},
    // leaving off: right contactor plus start pulse
    '{rms_pkg::CmdRefresh, rms_pkg::DirRight, 9'h000,       1'b1, 10'h108, 1'b0},
    '{rms_pkg::CmdTick,    rms_pkg::DirOff,   9'h000,       1'b0, '0,      1'b0},
    '{CmdReserved,         rms_pkg::DirLeft,  9'h1FF,       1'b0, '0,      1'b0},
    // right to left: both contactors open, dead time starts
    '{rms_pkg::CmdRefresh, rms_pkg::DirLeft,  9'b100000001, 1'b0, '0,      1'b0},
    '{rms_pkg::CmdTick,    rms_pkg::DirLeft,  9'h000,       1'b0, '0,      1'b0},
    '{rms_pkg::CmdRefresh, DirLeftAlt,        9'h000,       1'b0, '0,      1'b0},
    '{rms_pkg::CmdRefresh, rms_pkg::DirRight, 9'h000,       1'b0, '0,      1'b0},
    '{rms_pkg::CmdRefresh, rms_pkg::DirOff,   9'h000,       1'b0, '0,      1'b0},
    '{rms_pkg::CmdRefresh, rms_pkg::DirLeft,  9'b010110000, 1'b0, '0,      1'b0},
    '{rms_pkg::CmdTick,    rms_pkg::DirOff,   9'h1FF,       1'b0, '0,      1'b0},
    '{rms_pkg::CmdRefresh, rms_pkg::DirRight, 9'b011000000, 1'b0, '0,      1'b0},
    '{rms_pkg::CmdAllOff,  rms_pkg::DirOff,   9'h000,       1'b0, '0,      1'b0},
    '{rms_pkg::CmdTick,    rms_pkg::DirRight, 9'h000,       1'b0, '0,      1'b0},
    '{rms_pkg::CmdRefresh, rms_pkg::DirRight, 9'b011001111, 1'b0, '0,      1'b0},
    '{rms_pkg::CmdRefresh, rms_pkg::DirOff,   9'b100001110, 1'b0, '0,      1'b0},
    '{CmdReserved,         rms_pkg::DirOff,   9'h000,       1'b0, '0,      1'b0}
  };

  motor_reversal_relay_sequencer_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Idle cycles before a transaction on either side.
  function automatic int draw_gap();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Counter arms on first use: load minus one, or zero for a zero load.
  function automatic rms_pkg::cnt_t arm_count(rms_pkg::cnt_t c, rms_pkg::cnt_t load);
    if (c == load) return (load == '0) ? '0 : load - rms_pkg::cnt_t'(1);
    return c;
  endfunction

  // Tick: a started counter runs down to zero and stops there.
  function automatic rms_pkg::cnt_t tick_down(rms_pkg::cnt_t c, rms_pkg::cnt_t load);
    if (c != load && c != '0) return c - rms_pkg::cnt_t'(1);
    return c;
  endfunction

  // Advances the shadow state by one command and returns the relay report.
  function automatic relay_result_t next_relay_state(rms_pkg::item_t it);
    rms_pkg::relay_t r;
    bit go_right;
    rms_pkg::dir_e want;
    rms_pkg::dir_e away;
    int unsigned on_bit;
    int unsigned off_bit;
    relay_result_t res;
    r = relays;
    if (it.cmd == rms_pkg::CmdRefresh) begin
      r[rms_pkg::RlyAux] = it.aux_contact;
      if (it.motor_dir == rms_pkg::DirOff) begin
        r[rms_pkg::RlyStart] = 1'b0;
        r[rms_pkg::RlyIdle] = 1'b1;
        r[rms_pkg::RlyLeft] = 1'b0;
        r[rms_pkg::RlyRight] = 1'b0;
        rev_cnt = rev_ticks;
        pulse_cnt = pulse_ticks;
        last_dir = rms_pkg::DirOff;
      end else begin
        // code 3 falls through as left
        go_right = (it.motor_dir == rms_pkg::DirRight);
        want = go_right ? rms_pkg::DirRight : rms_pkg::DirLeft;
        away = go_right ? rms_pkg::DirLeft : rms_pkg::DirRight;
        on_bit = go_right ? rms_pkg::RlyRight : rms_pkg::RlyLeft;
        off_bit = go_right ? rms_pkg::RlyLeft : rms_pkg::RlyRight;
        if (last_dir == away) begin
          // reversal: contactors open until the dead time has run out;
          // start relay keeps whatever it had
          r[rms_pkg::RlyIdle] = 1'b0;
          r[rms_pkg::RlyLeft] = 1'b0;
          r[rms_pkg::RlyRight] = 1'b0;
          rev_cnt = arm_count(rev_cnt, rev_ticks);
          if (rev_cnt == '0) begin
            r[on_bit] = 1'b1;
            last_dir = want;
          end
        end else begin
          pulse_cnt = arm_count(pulse_cnt, pulse_ticks);
          r[rms_pkg::RlyStart] = (pulse_cnt != '0);
          r[rms_pkg::RlyIdle] = 1'b0;
          r[on_bit] = 1'b1;
          r[off_bit] = 1'b0;
          rev_cnt = rev_ticks;
          last_dir = want;
        end
      end
      if (it.irrigation_mode) begin
        r[rms_pkg::RlyPumpA] = it.main_pump;
        r[rms_pkg::RlyPumpB] = it.main_pump;
        if (it.wait_pressure || it.wait_start) begin
          r[rms_pkg::RlyFert] = 1'b0;
          r[rms_pkg::RlyBooster] = 1'b0;
          r[rms_pkg::RlyPerc] = 1'b0;
        end else begin
          r[rms_pkg::RlyFert] = it.fertigation;
          r[rms_pkg::RlyBooster] = it.booster_override | it.booster;
          r[rms_pkg::RlyPerc] = it.percentimeter;
        end
      end else begin
        r[rms_pkg::RlyFert] = 1'b0;
        r[rms_pkg::RlyBooster] = 1'b0;
        r[rms_pkg::RlyPerc] = it.percentimeter;
        r[rms_pkg::RlyPumpA] = 1'b0;
        r[rms_pkg::RlyPumpB] = 1'b0;
      end
    end else if (it.cmd == rms_pkg::CmdTick) begin
      rev_cnt = tick_down(rev_cnt, rev_ticks);
      pulse_cnt = tick_down(pulse_cnt, pulse_ticks);
    end else if (it.cmd == rms_pkg::CmdAllOff) begin
      // counters and direction survive an all-off
      r = '0;
    end
    relays = r;
    res.mask = r;
    res.reversing = (rev_cnt != rev_ticks) && (rev_cnt != '0);
    return res;
  endfunction

  // Random command: mostly refreshes and ticks around a slowly changing
  // direction request, so reversals actually complete; some noise on top.
  function automatic rms_pkg::item_t roll_item();
    rms_pkg::item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) it.cmd = rms_pkg::CmdRefresh;
    else if (pick < 85) it.cmd = rms_pkg::CmdTick;
    else if (pick < 93) it.cmd = rms_pkg::CmdAllOff;
    else it.cmd = CmdReserved;
    if ($urandom_range(0, 5) == 0) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) steer = rms_pkg::DirOff;
      else if (pick < 5) steer = rms_pkg::DirRight;
      else if (pick < 9) steer = rms_pkg::DirLeft;
      else steer = DirLeftAlt;
    end
    it.motor_dir = steer;
    {it.aux_contact, it.main_pump, it.fertigation, it.booster_override, it.booster,
     it.percentimeter} = 6'($urandom);
    it.irrigation_mode = ($urandom_range(0, 3) != 0);
    it.wait_pressure = ($urandom_range(0, 3) == 0);
    it.wait_start = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  // Presents one transaction and records its expected report on acceptance.
  // A typed row overrides the shadow's report; the shadow still advances.
  task automatic apply_command(input rms_pkg::item_t it, input bit typed,
                               input relay_result_t fixed);
    int gap;
    relay_result_t res;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, it.percentimeter, it.booster, it.booster_override, it.fertigation,
                     it.main_pump, it.wait_start, it.wait_pressure, it.irrigation_mode,
                     it.aux_contact, it.motor_dir};
    s_axis_tuser <= it.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    res = next_relay_state(it);
    expected_relays.push_back(typed ? fixed : res);
  endtask

  task automatic drain();
    while (expected_relays.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes both timing registers back to back while idle.
  task automatic load_timing(input rms_pkg::cnt_t rev, input rms_pkg::cnt_t pulse);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= rms_pkg::CfgRevTicks;
    cfg_data_i <= rev;
    @(posedge clk_i);
    cfg_idx_i <= rms_pkg::CfgPulseTicks;
    cfg_data_i <= pulse;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rev_ticks = rev;
    pulse_ticks = pulse;
  endtask

  task automatic run_phase(input rms_pkg::cnt_t rev, input rms_pkg::cnt_t pulse,
                           input bit quiet, input int n);
    drain();
    load_timing(rev, pulse);
    calm = quiet;
    repeat (n) apply_command(roll_item(), 1'b0, '0);
    s_axis_tvalid <= 1'b0;
  endtask

  // Result side: random back-pressure per transaction, compare in order.
  always @(posedge clk_i) begin
    relay_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_relays.size() == 0) begin
          $error("result transaction with nothing expected: %h", m_axis_tdata);
          errors++;
        end else begin
          want = expected_relays.pop_front();
          if (m_axis_tdata[rms_pkg::RelayCount-1:0] !== want.mask) begin
            $error("relay_mask: expected %h, got %h", want.mask,
                   m_axis_tdata[rms_pkg::RelayCount-1:0]);
            errors++;
          end
          if (m_axis_tdata[rms_pkg::RelayCount] !== want.reversing) begin
            $error("reversing: expected %b, got %b", want.reversing,
                   m_axis_tdata[rms_pkg::RelayCount]);
            errors++;
          end
        end
        sink_hold = draw_gap();
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    relay_result_t fixed;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset timing
    foreach (plan[i]) begin
      fixed.mask = plan[i].mask;
      fixed.reversing = plan[i].reversing;
      apply_command(rms_pkg::item_t'({plan[i].cmd, plan[i].dir, plan[i].flags}),
                    plan[i].typed, fixed);
    end
    s_axis_tvalid <= 1'b0;

    // random phases across timing settings, extremes and zero loads included
    run_phase(16'd1, 16'd1, 1'b0, 175);
    run_phase(16'd0, 16'd0, 1'b1, 175);
    run_phase(16'hFFFF, 16'hFFFF, 1'b0, 175);
    run_phase(16'd3, 16'd7, 1'b0, 175);
    run_phase(16'd8, 16'd2, 1'b1, 175);
    run_phase(16'd0, 16'd5, 1'b0, 175);
    run_phase(16'd5, 16'd0, 1'b0, 175);
    run_phase(rms_pkg::cnt_t'($urandom_range(1, 12)), rms_pkg::cnt_t'($urandom_range(1, 12)),
              1'b0, 175);
    run_phase(rms_pkg::cnt_t'($urandom_range(1, 12)), rms_pkg::cnt_t'($urandom_range(1, 12)),
              1'b0, 175);

    while (expected_relays.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
